// ===== design/icy_pkg.sv =====
// Shared types and constants for the ICY metadata demultiplexer.
package icy_pkg;

    localparam int BYTE_BITS       = 8;
    localparam int META_LEN_BITS   = 12;
    localparam int META_UNIT_SHIFT = 4;
    localparam int TDATA_BITS      = 24;

    typedef enum logic [1:0] {
        MODE_AUDIO   = 2'd0,
        MODE_LENGTH  = 2'd1,
        MODE_PAYLOAD = 2'd2
    } parse_mode_t;

    typedef struct packed {
        logic [BYTE_BITS-1:0]     out_byte;
        logic                     byte_kind;
        logic                     meta_last;
        logic [META_LEN_BITS-1:0] meta_keep_length;
    } result_t;

endpackage

// ===== design/icy_metadata_demux.sv =====
// A result is registered into the output stage when its byte is accepted.
// One byte per cycle while s_tready is set; parser state is updated in the accepting cycle.
// A length byte, or a zero length, produces no result.
// A two-entry output stage holds results while the master side stalls.
// Reset (async, active low) clears the interval to zero (pass-through) and empties the output.
// Writing the interval restarts audio counting.
module icy_metadata_demux #(
    parameter int INTERVAL_BITS = 20
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [INTERVAL_BITS-1:0]       cfg_wr_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] data_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [icy_pkg::TDATA_BITS-1:0] m_tdata,   // [7:0] out_byte, [19:8] meta_keep_length
    output logic                           m_tlast,   // meta_last
    output logic                           m_tuser    // [0] byte_kind
);

    logic             in_accept;
    logic             res_valid;
    icy_pkg::result_t res;
    icy_pkg::result_t out_res;

    assign in_accept = s_tvalid & s_tready;

    icy_parser #(
        .INTERVAL_BITS (INTERVAL_BITS)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_accept   (in_accept),
        .in_byte     (s_tdata),
        .res_valid   (res_valid),
        .res         (res)
    );

    icy_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept & res_valid),
        .push_data (res),
        .ready     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {{(icy_pkg::TDATA_BITS - icy_pkg::META_LEN_BITS - icy_pkg::BYTE_BITS){1'b0}},
                      out_res.meta_keep_length, out_res.out_byte};
    assign m_tlast = out_res.meta_last;
    assign m_tuser = out_res.byte_kind;

endmodule

// ===== design/icy_parser.sv =====
// Parse state and per-byte split of the stream into audio and metadata results.
module icy_parser #(
    parameter int INTERVAL_BITS = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [INTERVAL_BITS-1:0]      cfg_wr_data,
    input  logic                          in_accept,
    input  logic [icy_pkg::BYTE_BITS-1:0] in_byte,
    output logic                          res_valid,
    output icy_pkg::result_t              res
);

    localparam int LB = icy_pkg::META_LEN_BITS;

    logic [INTERVAL_BITS-1:0] interval_reg;
    icy_pkg::parse_mode_t     mode_reg, mode_next;
    logic [INTERVAL_BITS-1:0] countdown_reg, countdown_next;
    logic [LB-1:0]            remaining_reg, remaining_next;
    logic [LB-1:0]            position_reg, position_next;
    logic [LB-1:0]            last_nz_reg, last_nz_next;

    logic [LB-1:0]            pos_inc;
    logic [LB-1:0]            last_nz_upd;
    logic [LB-1:0]            block_len;
    logic [INTERVAL_BITS-1:0] countdown_dec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg  <= '0;
            mode_reg      <= icy_pkg::MODE_AUDIO;
            countdown_reg <= '0;
            remaining_reg <= '0;
            position_reg  <= '0;
            last_nz_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            // restart counting from the new interval
            interval_reg  <= cfg_wr_data;
            mode_reg      <= icy_pkg::MODE_AUDIO;
            countdown_reg <= cfg_wr_data;
            remaining_reg <= '0;
            position_reg  <= '0;
            last_nz_reg   <= '0;
        end
        else if (in_accept)
        begin
            mode_reg      <= mode_next;
            countdown_reg <= countdown_next;
            remaining_reg <= remaining_next;
            position_reg  <= position_next;
            last_nz_reg   <= last_nz_next;
        end
    end

    assign pos_inc       = position_reg + 1'b1;
    assign last_nz_upd   = (in_byte != '0) ? pos_inc : last_nz_reg;
    assign block_len     = {in_byte, {icy_pkg::META_UNIT_SHIFT{1'b0}}};
    assign countdown_dec = countdown_reg - 1'b1;

    always_comb
    begin
        mode_next            = mode_reg;
        countdown_next       = countdown_reg;
        remaining_next       = remaining_reg;
        position_next        = position_reg;
        last_nz_next         = last_nz_reg;
        res_valid            = 1'b0;
        res.out_byte         = in_byte;
        res.byte_kind        = 1'b0;
        res.meta_last        = 1'b0;
        res.meta_keep_length = '0;

        if (interval_reg == '0)
        begin
            // parsing disabled: pass through, state untouched
            res_valid = 1'b1;
        end
        else
        begin
            case (mode_reg)
                icy_pkg::MODE_LENGTH:
                begin
                    if (in_byte == '0)
                    begin
                        mode_next      = icy_pkg::MODE_AUDIO;
                        countdown_next = interval_reg;
                        remaining_next = '0;
                    end
                    else
                    begin
                        mode_next      = icy_pkg::MODE_PAYLOAD;
                        remaining_next = block_len;
                    end
                    position_next = '0;
                    last_nz_next  = '0;
                end
                icy_pkg::MODE_PAYLOAD:
                begin
                    res_valid     = 1'b1;
                    res.byte_kind = 1'b1;
                    if (remaining_reg <= LB'(1))
                    begin
                        res.meta_last        = 1'b1;
                        res.meta_keep_length = last_nz_upd;
                        mode_next            = icy_pkg::MODE_AUDIO;
                        countdown_next       = interval_reg;
                        remaining_next       = '0;
                        position_next        = '0;
                        last_nz_next         = '0;
                    end
                    else
                    begin
                        remaining_next = remaining_reg - 1'b1;
                        position_next  = pos_inc;
                        last_nz_next   = last_nz_upd;
                    end
                end
                default:
                begin
                    // audio mode, also taken for the unused code
                    mode_next = icy_pkg::MODE_AUDIO;
                    if (countdown_reg == '0)
                    begin
                        // exhausted countdown: this byte is the length byte
                        if (in_byte == '0)
                        begin
                            countdown_next = interval_reg;
                            remaining_next = '0;
                        end
                        else
                        begin
                            mode_next      = icy_pkg::MODE_PAYLOAD;
                            remaining_next = block_len;
                        end
                        position_next = '0;
                        last_nz_next  = '0;
                    end
                    else
                    begin
                        res_valid      = 1'b1;
                        countdown_next = countdown_dec;
                        if (countdown_dec == '0)
                        begin
                            mode_next = icy_pkg::MODE_LENGTH;
                        end
                    end
                end
            endcase
        end
    end

endmodule

// ===== design/icy_out_skid.sv =====
// Output register with a skid stage so the input side keeps a registered ready.
module icy_out_skid (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  icy_pkg::result_t push_data,
    output logic             ready,
    output logic             out_valid,
    input  logic             out_ready,
    output icy_pkg::result_t out_data
);

    logic             main_valid_reg, main_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    icy_pkg::result_t main_data_reg, main_data_next;
    icy_pkg::result_t skid_data_reg, skid_data_next;
    logic             pop;

    assign pop       = main_valid_reg & out_ready;
    assign ready     = ~skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            // drain the skid entry into the output register
            if (pop)
            begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
            else
            begin
                main_data_next  = push_data;
                main_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

endmodule

// ===== dv/icy_metadata_demux_tb.sv =====
// Self-checking testbench for the ICY metadata demultiplexer with a local predictor.
module icy_metadata_demux_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          IVL_BITS   = 20;
    localparam int unsigned IVL_MAX    = (32'd1 << IVL_BITS) - 32'd1;
    localparam int          CLK_PERIOD = 10;
    localparam int          HOLD_LEN   = 400;
    localparam int          QUIET_MAX  = 4000;
    localparam int          SETTLE     = 4;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_wr_en;
    logic [IVL_BITS-1:0]            cfg_wr_data;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [7:0]                     s_tdata;   // [7:0] data_byte
    logic                           m_tvalid;
    logic                           m_tready;
    logic [icy_pkg::TDATA_BITS-1:0] m_tdata;   // [7:0] out_byte, [19:8] meta_keep_length
    logic                           m_tlast;   // meta_last
    logic                           m_tuser;   // [0] byte_kind

    icy_metadata_demux #(
        .INTERVAL_BITS(IVL_BITS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    // stream bytes waiting to be offered, and demuxed bytes still owed by the block
    logic [7:0]       stream_bytes[$];
    icy_pkg::result_t expected_bytes[$];

    // predictor state
    logic [IVL_BITS-1:0]  ivl_q;
    icy_pkg::parse_mode_t mode_q;
    logic [IVL_BITS-1:0]  audio_left_q;
    logic [11:0]          meta_left_q;
    logic [11:0]          meta_pos_q;
    logic [11:0]          keep_end_q;

    int   errors;
    int   quiet_cycles;
    logic in_taken;
    logic no_idle;
    int   stall_req;
    int   stall_done;
    int   hold_left;

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic void restart_audio();
        mode_q       = icy_pkg::MODE_AUDIO;
        audio_left_q = ivl_q;
        meta_left_q  = '0;
        meta_pos_q   = '0;
        keep_end_q   = '0;
    endfunction

    function automatic void take_length(input logic [7:0] b);
        logic [12:0] len;
        len = {1'b0, b, 4'd0};
        if (len == 0)
        begin
            restart_audio();
        end
        else
        begin
            meta_left_q = len[11:0];
            meta_pos_q  = '0;
            keep_end_q  = '0;
            mode_q      = icy_pkg::MODE_PAYLOAD;
        end
    endfunction

    function automatic void owe(input logic [7:0] b, input logic kind, input logic last,
                                input logic [11:0] keep);
        icy_pkg::result_t r;
        r.out_byte         = b;
        r.byte_kind        = kind;
        r.meta_last        = last;
        r.meta_keep_length = keep;
        expected_bytes.push_back(r);
    endfunction

    // work out what one accepted stream byte turns into
    function automatic void split_byte(input logic [7:0] b);
        logic [11:0] keep;
        if (ivl_q == 0)
        begin
            owe(b, 1'b0, 1'b0, '0);
        end
        else if (mode_q == icy_pkg::MODE_LENGTH)
        begin
            take_length(b);
        end
        else if (mode_q == icy_pkg::MODE_PAYLOAD)
        begin
            meta_pos_q = meta_pos_q + 1'b1;
            if (b != 0)
                keep_end_q = meta_pos_q;
            if (meta_left_q <= 1)
            begin
                keep = keep_end_q;
                restart_audio();
                owe(b, 1'b1, 1'b1, keep);
            end
            else
            begin
                meta_left_q = meta_left_q - 1'b1;
                owe(b, 1'b1, 1'b0, '0);
            end
        end
        else
        begin
            mode_q = icy_pkg::MODE_AUDIO;
            if (audio_left_q == 0)
            begin
                take_length(b);
            end
            else
            begin
                audio_left_q = audio_left_q - 1'b1;
                if (audio_left_q == 0)
                    mode_q = icy_pkg::MODE_LENGTH;
                owe(b, 1'b0, 1'b0, '0);
            end
        end
    endfunction

    function automatic void check_result();
        icy_pkg::result_t want;
        if (expected_bytes.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: byte %02h kind %0d last %0d keep %0d",
                         m_tdata[7:0], m_tuser, m_tlast, m_tdata[19:8]);
            return;
        end
        want = expected_bytes.pop_front();
        if (m_tdata[7:0] !== want.out_byte || m_tuser !== want.byte_kind ||
            m_tlast !== want.meta_last || m_tdata[19:8] !== want.meta_keep_length)
        begin
            errors++;
            if (errors <= 10)
                $display({"mismatch: expected byte %02h kind %0d last %0d keep %0d, ",
                          "got byte %02h kind %0d last %0d keep %0d"},
                         want.out_byte, want.byte_kind, want.meta_last,
                         want.meta_keep_length,
                         m_tdata[7:0], m_tuser, m_tlast, m_tdata[19:8]);
        end
    endfunction

    // monitor: sample both sides at the rising edge, check, then predict
    always @(posedge clk)
    begin
        in_taken <= s_tvalid && s_tready;
        if (rst_n)
        begin
            if (cfg_wr_en)
            begin
                ivl_q = cfg_wr_data;
                restart_audio();
            end
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready)
                split_byte(s_tdata);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || cfg_wr_en)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_MAX)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // driver: advance to the next byte once the current request is taken
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (stream_bytes.size() != 0 && (no_idle || $urandom_range(99) >= 32))
            begin
                s_tdata  <= stream_bytes.pop_front();
                s_tvalid <= 1'b1;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random back-pressure plus long hold-offs on request
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_req != stall_done)
            begin
                stall_done++;
                hold_left = HOLD_LEN;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= no_idle || ($urandom_range(99) >= 32);
            end
        end
    end

    task automatic queue_payload(input int len, input int tz);
        int j;
        for (j = 0; j < len; j++)
        begin
            if (j >= len - tz)
                stream_bytes.push_back(8'h00);
            else if (j == len - tz - 1)
                stream_bytes.push_back(8'($urandom_range(1, 255)));
            else if ($urandom_range(9) == 0)
                stream_bytes.push_back(8'h00);
            else
                stream_bytes.push_back(8'($urandom_range(255)));
        end
    endtask

    // well-formed ICY traffic: interval audio bytes, a length byte, then its payload
    task automatic queue_stream(input int unsigned ivl, input int n);
        int          cnt;
        int unsigned k;
        int          r;
        int          len;
        int          tz;
        logic [7:0]  lb;
        cnt = 0;
        while (cnt < n)
        begin
            if (ivl == 0)
            begin
                stream_bytes.push_back(8'($urandom));
                cnt++;
            end
            else
            begin
                for (k = 0; k < ivl && cnt < n; k++)
                begin
                    stream_bytes.push_back(8'($urandom));
                    cnt++;
                end
                if (cnt < n)
                begin
                    r = $urandom_range(99);
                    if (r < 25)
                        lb = 8'h00;
                    else if (r < 88)
                        lb = 8'($urandom_range(1, 2));
                    else if (r < 98)
                        lb = 8'($urandom_range(3, 6));
                    else
                        lb = 8'($urandom_range(7, 16));
                    stream_bytes.push_back(lb);
                    cnt++;
                    len = int'(lb) * 16;
                    r = $urandom_range(3);
                    if (len == 0 || r == 0)
                        tz = 0;
                    else if (r == 3)
                        tz = len;
                    else
                        tz = $urandom_range(len);
                    queue_payload(len, tz);
                    cnt += len;
                end
            end
        end
    endtask

    task automatic wait_idle();
        do
        begin
            @(negedge clk);
            #1;
        end while (stream_bytes.size() != 0 || s_tvalid || expected_bytes.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_interval(input logic [IVL_BITS-1:0] v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int unsigned ivl;
        int unsigned k;
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        in_taken     = 1'b0;
        no_idle      = 1'b0;
        errors       = 0;
        quiet_cycles = 0;
        stall_req    = 0;
        stall_done   = 0;
        hold_left    = 0;
        ivl_q        = '0;
        restart_audio();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // pass-through straight out of reset
        stream_bytes.push_back(8'h00);
        stream_bytes.push_back(8'hFF);
        stream_bytes.push_back(8'hA5);
        stream_bytes.push_back(8'h5A);
        queue_stream(0, 60);
        wait_idle();

        // interval of one: zero length, trailing NULs, an all-NUL block
        set_interval(20'd1);
        stream_bytes.push_back(8'hFF);
        stream_bytes.push_back(8'h00);
        stream_bytes.push_back(8'h3C);
        stream_bytes.push_back(8'h01);
        queue_payload(16, 4);
        stream_bytes.push_back(8'h7E);
        stream_bytes.push_back(8'h01);
        queue_payload(16, 16);
        queue_stream(1, 100);
        wait_idle();

        // long block, ending on a nonzero byte
        set_interval(20'd1);
        stream_bytes.push_back(8'h01);
        stream_bytes.push_back(8'h08);
        queue_payload(128, 0);
        stream_bytes.push_back(8'h02);
        wait_idle();

        // full rate on both sides
        no_idle = 1'b1;
        set_interval(20'd3);
        queue_stream(3, 150);
        wait_idle();
        no_idle = 1'b0;

        // hold off the receiver while the sender keeps pushing
        set_interval(20'd16);
        queue_stream(16, 200);
        stall_req++;
        wait_idle();

        set_interval(20'd0);
        queue_stream(0, 60);
        wait_idle();

        set_interval(IVL_BITS'(IVL_MAX));
        queue_stream(IVL_MAX, 50);
        wait_idle();

        // end mid-payload so the next write restarts a half-read block
        ivl = $urandom_range(1, 8);
        set_interval(IVL_BITS'(ivl));
        for (k = 0; k < ivl; k++)
            stream_bytes.push_back(8'($urandom));
        stream_bytes.push_back(8'h03);
        queue_payload(10, 0);
        wait_idle();

        set_interval(20'd2);
        queue_stream(2, 150);
        wait_idle();

        errors += expected_bytes.size();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
